// File: hw/rtl/style_intern_table_defines.svh
// Assertion macros for the style intern table RTL.
`ifndef STYLE_INTERN_TABLE_DEFINES_SVH
`define STYLE_INTERN_TABLE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define SIT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define SIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/sit_pkg.sv
// Types and codes shared by the style intern table modules.
package sit_pkg;

    localparam int WORD_W  = 64;
    localparam int ID_W    = 7;
    localparam int COUNT_W = 8;
    localparam int INDEX_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_GET = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_GET
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] default_style;
        logic [WORD_W-1:0] fallback_style;
        logic [WORD_W-1:0] border_mask;
    } t_cfg;

    typedef struct packed {
        logic               status;
        logic [ID_W-1:0]    entry_id;
        logic [WORD_W-1:0]  read_style;
        logic [COUNT_W-1:0] entry_count;
        logic               border_used;
    } t_result;

endpackage

// File: hw/rtl/sit_store.sv
// Style word memory: one write port, one read port with registered data.
module sit_store #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/sit_ctrl.sv
// Sequencer for add and get items: scans the store one entry per cycle.
`include "style_intern_table_defines.svh"

module sit_ctrl #(
    parameter int MAX_STYLES = 128,
    parameter int STYLE_BITS = 64,
    parameter int IW = $clog2(MAX_STYLES),
    parameter int CW = $clog2(MAX_STYLES + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_mode,
    input  logic [STYLE_BITS-1:0]        i_style,
    input  logic [sit_pkg::INDEX_W-1:0]  i_index,
    input  sit_pkg::t_cfg                i_cfg,
    output logic                         o_busy,
    output logic                         o_done,
    output sit_pkg::t_result             o_res,
    output logic [IW-1:0]                o_rd_addr,
    input  logic [STYLE_BITS-1:0]        i_rd_data,
    output logic                         o_wr_en,
    output logic [IW-1:0]                o_wr_addr,
    output logic [STYLE_BITS-1:0]        o_wr_data
);

    sit_pkg::t_state  r_state, n_state;
    logic [IW-1:0]    r_scan_idx, n_scan_idx;
    logic [CW-1:0]    r_count, n_count;
    logic             r_border, n_border;
    logic             r_done, n_done;
    sit_pkg::t_result r_res, n_res;

    logic [STYLE_BITS-1:0]       r_word;
    logic [sit_pkg::INDEX_W-1:0] r_index;

    logic [STYLE_BITS-1:0] dflt;
    logic [STYLE_BITS-1:0] fallback;
    logic [STYLE_BITS-1:0] bmask;
    logic [STYLE_BITS-1:0] cur_entry;

    assign dflt     = i_cfg.default_style[STYLE_BITS-1:0];
    assign fallback = i_cfg.fallback_style[STYLE_BITS-1:0];
    assign bmask    = i_cfg.border_mask[STYLE_BITS-1:0];

    // Entry zero is the live default register, not the memory.
    assign cur_entry = (r_scan_idx == '0) ? dflt : i_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sit_pkg::ST_IDLE;
            r_scan_idx <= '0;
            r_count    <= CW'(1);
            r_border   <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_scan_idx <= n_scan_idx;
            r_count    <= n_count;
            r_border   <= n_border;
            r_done     <= n_done;
        end
    end

    // Payload: capture the item on accept, the result on completion.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == sit_pkg::ST_IDLE && i_start) begin
            r_word  <= i_style;
            r_index <= i_index;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_scan_idx = r_scan_idx;
        n_count    = r_count;
        n_border   = r_border;
        n_done     = 1'b0;
        n_res      = r_res;
        o_rd_addr  = '0;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_count[IW-1:0];
        o_wr_data  = r_word;

        unique case (r_state)
            sit_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_scan_idx = '0;
                    if (i_mode == sit_pkg::MODE_GET) begin
                        n_state   = sit_pkg::ST_GET;
                        o_rd_addr = i_index[IW-1:0];
                    end else begin
                        n_state = sit_pkg::ST_SCAN;
                    end
                end
            end

            sit_pkg::ST_SCAN: begin
                // Prefetch the next entry while comparing this one.
                o_rd_addr = r_scan_idx + 1'b1;
                n_res.read_style = '0;
                if (cur_entry == r_word) begin
                    n_state            = sit_pkg::ST_IDLE;
                    n_done             = 1'b1;
                    n_res.status       = sit_pkg::STATUS_OK;
                    n_res.entry_id     = sit_pkg::ID_W'(r_scan_idx);
                    n_res.entry_count  = sit_pkg::COUNT_W'(r_count);
                    n_res.border_used  = r_border;
                end else if (r_scan_idx == IW'(r_count - 1'b1)) begin
                    n_state = sit_pkg::ST_IDLE;
                    n_done  = 1'b1;
                    if (r_count == CW'(MAX_STYLES)) begin
                        n_res.status   = sit_pkg::STATUS_FULL;
                        n_res.entry_id = '0;
                    end else begin
                        // Append at the first free slot.
                        o_wr_en        = 1'b1;
                        n_count        = r_count + 1'b1;
                        n_border       = r_border | (|(r_word & bmask));
                        n_res.status   = sit_pkg::STATUS_OK;
                        n_res.entry_id = sit_pkg::ID_W'(r_count);
                    end
                    n_res.entry_count = sit_pkg::COUNT_W'(n_count);
                    n_res.border_used = n_border;
                end else begin
                    n_scan_idx = r_scan_idx + 1'b1;
                end
            end

            sit_pkg::ST_GET: begin
                n_state           = sit_pkg::ST_IDLE;
                n_done            = 1'b1;
                n_res.status      = sit_pkg::STATUS_OK;
                n_res.entry_id    = '0;
                n_res.entry_count = sit_pkg::COUNT_W'(r_count);
                n_res.border_used = r_border;
                if (9'(r_index) < 9'(r_count)) begin
                    n_res.read_style = sit_pkg::WORD_W'(
                        (r_index == '0) ? dflt : i_rd_data);
                end else begin
                    n_res.read_style = sit_pkg::WORD_W'(fallback);
                end
            end

            default: begin
                n_state = sit_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != sit_pkg::ST_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    `SIT_ASSERT_NOW(a_count_range, 1'b1, (r_count != '0) && (r_count <= CW'(MAX_STYLES)), "entry count out of range")
    `SIT_ASSERT_NOW(a_write_room, o_wr_en, r_count < CW'(MAX_STYLES), "append with no free entry")
    `SIT_ASSERT_NEXT(a_done_after_work, r_state != sit_pkg::ST_IDLE && n_state == sit_pkg::ST_IDLE, r_done, "item finished without result strobe")
    `SIT_ASSERT_NOW(a_full_status, r_done && r_res.status == sit_pkg::STATUS_FULL, r_count == CW'(MAX_STYLES), "full reported below capacity")

endmodule

// File: hw/rtl/style_intern_table.sv
// Top level of the style intern table: configuration registers, sequencer and store.
//
// Interns style words. An add item (mode 0) compares the word against the held
// entries in index order, one entry per clock from the single memory read port,
// and returns the first matching index, appends the word, or reports full status
// when no entry is free. A get item (mode 1) returns the entry at i_entry_index,
// or fallback_style when that index is not held. The result strobe o_done lasts
// one cycle and cannot be stalled; busy falls in that same cycle, so the next
// start may be taken alongside it. Entry 0 always reads as the current
// default_style register.
module style_intern_table #(
    parameter int MAX_STYLES = 128,
    parameter int STYLE_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [sit_pkg::WORD_W-1:0]    i_style_value,
    input  logic [sit_pkg::INDEX_W-1:0]   i_entry_index,
    output logic                          o_done,
    output logic                          o_status,
    output logic [sit_pkg::ID_W-1:0]      o_entry_id,
    output logic [sit_pkg::WORD_W-1:0]    o_read_style,
    output logic [sit_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                          o_border_used,
    input  logic                          i_cfg_we,
    input  logic [sit_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sit_pkg::WORD_W-1:0]    i_cfg_data
);

    localparam int IW = $clog2(MAX_STYLES);
    localparam int CW = $clog2(MAX_STYLES + 1);

    sit_pkg::t_cfg    r_cfg;
    sit_pkg::t_result res;

    logic [IW-1:0]         rd_addr;
    logic [STYLE_BITS-1:0] rd_data;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [STYLE_BITS-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sit_pkg::CFG_DEFAULT:  r_cfg.default_style  <= i_cfg_data;
                sit_pkg::CFG_FALLBACK: r_cfg.fallback_style <= i_cfg_data;
                sit_pkg::CFG_BORDER:   r_cfg.border_mask    <= i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    sit_ctrl #(
        .MAX_STYLES (MAX_STYLES),
        .STYLE_BITS (STYLE_BITS),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_mode    (i_mode),
        .i_style   (i_style_value[STYLE_BITS-1:0]),
        .i_index   (i_entry_index),
        .i_cfg     (r_cfg),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_res     (res),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    sit_store #(
        .DEPTH (MAX_STYLES),
        .WIDTH (STYLE_BITS),
        .AW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_status      = res.status;
    assign o_entry_id    = res.entry_id;
    assign o_read_style  = res.read_style;
    assign o_entry_count = res.entry_count;
    assign o_border_used = res.border_used;

endmodule
